// ----- sv/ste_pkg.sv -----
// ----------------------------------------------------------------------------
// ste_pkg
// shared widths, register indexes and pipeline types of the 3d stencil
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = 18;
  localparam int X_W     = 6;
  localparam int Y_W     = 6;
  localparam int Z_W     = 8;
  localparam int LEN_W   = 7;
  localparam int BANK_W  = 2;
  localparam int NBANK   = 4;
  localparam int NHALF   = 2;
  localparam int RAM_AW  = Y_W - BANK_W + X_W;
  localparam int PROD_W  = DATA_W + COEF_W;
  localparam int ACC_W   = 56;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 3;

  localparam logic [X_W-1:0] X_MAX = '1;
  localparam logic [Y_W-1:0] Y_MAX = '1;
  localparam logic [Z_W-1:0] Z_MAX = '1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_CENTER  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_X_MINUS = 3'd1;
  localparam logic [IDX_W-1:0] CFG_X_PLUS  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_Y_MINUS = 3'd3;
  localparam logic [IDX_W-1:0] CFG_Y_PLUS  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_Z_MINUS = 3'd5;
  localparam logic [IDX_W-1:0] CFG_Z_PLUS  = 3'd6;

  // position and decision for one request
  typedef struct packed {
    logic           emit;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    logic           sel;
  } ctrl_t;

endpackage

// ----- sv/ste_ram.sv -----
// ----------------------------------------------------------------------------
// ste_ram
// one write port, two registered read ports, read-before-write
// ----------------------------------------------------------------------------
module ste_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] ra_a,
  input  logic [AW-1:0] ra_b,
  output logic [DW-1:0] qa,
  output logic [DW-1:0] qb,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd
);

  logic [DW-1:0] mem [2**AW];

  // reads see the contents from before a write in the same cycle
  always_ff @(posedge clk) begin
    if (re) begin
      qa <= mem[ra_a];
      qb <= mem[ra_b];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

endmodule

// ----- sv/ste_ctrl.sv -----
// ----------------------------------------------------------------------------
// ste_ctrl
// raster counters, learned grid sizes and the emit decision
// ----------------------------------------------------------------------------
module ste_ctrl
  import ste_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  logic  row_end,
  input  logic  plane_end,
  input  logic  grid_end,
  output ctrl_t ctl
);

  logic [X_W-1:0]   col_r, col_nxt;
  logic [Y_W-1:0]   row_r, row_nxt;
  logic [Z_W-1:0]   plane_r, plane_nxt;
  logic [LEN_W-1:0] lrl_r, lrl_nxt;
  logic [LEN_W-1:0] lpr_r, lpr_nxt;
  logic             sel_r, sel_nxt;
  logic             g_end, p_end, r_end;

  assign g_end = grid_end;
  assign p_end = grid_end | plane_end;
  assign r_end = p_end | row_end;

  // interior test of the centre point one plane back
  assign ctl.emit = (plane_r >= Z_W'(2)) && (col_r != '0) && (row_r != '0) &&
                    ({2'b00, col_r} + 8'd2 <= {1'b0, lrl_r}) &&
                    ({2'b00, row_r} + 8'd2 <= {1'b0, lpr_r});
  assign ctl.x    = col_r;
  assign ctl.y    = row_r;
  assign ctl.z    = plane_r - Z_W'(1);
  assign ctl.sel  = sel_r;

  // next counter values
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    sel_nxt   = sel_r;
    lrl_nxt   = r_end ? ({1'b0, col_r} + LEN_W'(1)) : lrl_r;
    lpr_nxt   = p_end ? ({1'b0, row_r} + LEN_W'(1)) : lpr_r;
    if (g_end) begin
      col_nxt   = '0;
      row_nxt   = '0;
      plane_nxt = '0;
      sel_nxt   = 1'b0;
    end else if (p_end) begin
      col_nxt = '0;
      row_nxt = '0;
      if (plane_r != Z_MAX) plane_nxt = plane_r + Z_W'(1);
      sel_nxt = ~sel_r;
    end else if (r_end) begin
      col_nxt = '0;
      if (row_r != Y_MAX) row_nxt = row_r + Y_W'(1);
    end else begin
      if (col_r != X_MAX) col_nxt = col_r + X_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
      lrl_r   <= '0;
      lpr_r   <= '0;
      sel_r   <= 1'b0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      lrl_r   <= lrl_nxt;
      lpr_r   <= lpr_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// ----- sv/ste_dp.sv -----
// ----------------------------------------------------------------------------
// ste_dp
// weights, products, adder tree, shift and saturation, output register
// ----------------------------------------------------------------------------
module ste_dp
  import ste_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_idx,
  input  logic [COEF_W-1:0]        cfg_val,
  input  logic                     adv,
  input  logic                     s1_vld,
  input  ctrl_t                    s1_ctl,
  input  logic signed [DATA_W-1:0] op_xm,
  input  logic signed [DATA_W-1:0] op_xp,
  input  logic signed [DATA_W-1:0] op_ym,
  input  logic signed [DATA_W-1:0] op_yp,
  input  logic signed [DATA_W-1:0] op_zm,
  input  logic signed [DATA_W-1:0] op_zp,
  output logic                     out_vld,
  output logic signed [DATA_W-1:0] out_val,
  output logic [X_W-1:0]           out_x,
  output logic [Y_W-1:0]           out_y,
  output logic [Z_W-1:0]           out_z
);

  logic signed [COEF_W-1:0] coef_r [7];
  logic signed [DATA_W-1:0] win_r;
  logic signed [PROD_W-1:0] p_r [7];
  logic signed [ACC_W-1:0]  sa_r, sb_r, sc_r;
  logic signed [ACC_W-1:0]  tot;
  logic signed [ACC_W-1:0]  sh;
  logic signed [DATA_W-1:0] sat;
  logic                     v2_r, v3_r, vo_r;
  ctrl_t                    c2_r, c3_r, co_r;
  logic signed [DATA_W-1:0] val_r;

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CENTER:  coef_r[0] <= cfg_val;
        CFG_X_MINUS: coef_r[1] <= cfg_val;
        CFG_X_PLUS:  coef_r[2] <= cfg_val;
        CFG_Y_MINUS: coef_r[3] <= cfg_val;
        CFG_Y_PLUS:  coef_r[4] <= cfg_val;
        CFG_Z_MINUS: coef_r[5] <= cfg_val;
        CFG_Z_PLUS:  coef_r[6] <= cfg_val;
        default: ;
      endcase
    end
  end

  // centre comes from the x plus one read of the previous request
  always_ff @(posedge clk) begin
    if (adv && s1_vld) win_r <= op_xp;
  end

  // final sum, floor shift and clamp
  assign tot = sa_r + sb_r + sc_r;
  assign sh  = tot >>> FRAC_W;
  always_comb begin
    if (&sh[ACC_W-1:DATA_W-1] || ~|sh[ACC_W-1:DATA_W-1]) begin
      sat = sh[DATA_W-1:0];
    end else if (sh[ACC_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= coef_r[0] * win_r;
      p_r[1] <= coef_r[1] * op_xm;
      p_r[2] <= coef_r[2] * op_xp;
      p_r[3] <= coef_r[3] * op_ym;
      p_r[4] <= coef_r[4] * op_yp;
      p_r[5] <= coef_r[5] * op_zm;
      p_r[6] <= coef_r[6] * op_zp;
      c2_r   <= s1_ctl;
      sa_r   <= ACC_W'(p_r[0]) + ACC_W'(p_r[1]) + ACC_W'(p_r[2]);
      sb_r   <= ACC_W'(p_r[3]) + ACC_W'(p_r[4]);
      sc_r   <= ACC_W'(p_r[5]) + ACC_W'(p_r[6]);
      c3_r   <= c2_r;
      val_r  <= sat;
      co_r   <= c3_r;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v2_r <= s1_vld && s1_ctl.emit;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  assign out_vld = vo_r;
  assign out_val = val_r;
  assign out_x   = co_r.x;
  assign out_y   = co_r.y;
  assign out_z   = co_r.z;

endmodule

// ----- sv/stencil_3d_seven_point.sv -----
// ----------------------------------------------------------------------------
// stencil_3d_seven_point
// seven-point 3d stencil over a padded raster stream, two planes in memory
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the output is not stalled, set by
//   the single write of each voxel into its plane bank
// pipeline: stage one, products, partial sums, output register
// reset: rst_n clears counters, learned sizes, weights and pipeline valids;
//   the plane memories are not cleared
module stencil_3d_seven_point
  import ste_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] voxel_in
  input  logic [1:0]        in_tuser,   // [0] row_end, [1] plane_end
  input  logic              in_tlast,   // grid_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,  // voxel_out, out_x, out_y, out_z, pad
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  logic              accept, adv;
  ctrl_t             ctl;
  logic              s1_vld_r;
  ctrl_t             s1_ctl_r;
  logic [DATA_W-1:0] s1_v_r;
  logic [DATA_W-1:0] qa [NHALF*NBANK];
  logic [DATA_W-1:0] qb [NHALF*NBANK];
  logic [Y_W-1:0]    ym, yp;
  logic [BANK_W:0]   i_c, i_m, i_p, i_o;
  logic              out_vld;
  logic signed [DATA_W-1:0] out_val;
  logic [X_W-1:0]    ox;
  logic [Y_W-1:0]    oy;
  logic [Z_W-1:0]    oz;

  // handshake
  assign adv       = !(out_vld && !out_tready);
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ste_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .row_end   (in_tuser[0]),
    .plane_end (in_tuser[1]),
    .grid_end  (in_tlast),
    .ctl       (ctl)
  );

  assign ym = ctl.y - Y_W'(1);
  assign yp = ctl.y + Y_W'(1);

  // plane banks: two halves, four row banks each
  for (genvar h = 0; h < NHALF; h++) begin : g_half
    for (genvar b = 0; b < NBANK; b++) begin : g_bank
      logic              is_prev;
      logic [RAM_AW-1:0] ra_a, ra_b;
      logic              we;
      assign is_prev = (ctl.sel != h[0]);
      always_comb begin
        ra_b = {ctl.y[Y_W-1:BANK_W], ctl.x - X_W'(1)};
        if (!is_prev) begin
          ra_a = {ctl.y[Y_W-1:BANK_W], ctl.x};
        end else if (ctl.y[BANK_W-1:0] == b[BANK_W-1:0]) begin
          ra_a = {ctl.y[Y_W-1:BANK_W], ctl.x + X_W'(1)};
        end else if (ym[BANK_W-1:0] == b[BANK_W-1:0]) begin
          ra_a = {ym[Y_W-1:BANK_W], ctl.x};
        end else begin
          ra_a = {yp[Y_W-1:BANK_W], ctl.x};
        end
      end
      assign we = accept && !is_prev && (ctl.y[BANK_W-1:0] == b[BANK_W-1:0]);
      ste_ram #(.AW(RAM_AW), .DW(DATA_W)) u_ram (
        .clk  (clk),
        .re   (accept),
        .ra_a (ra_a),
        .ra_b (ra_b),
        .qa   (qa[h*NBANK+b]),
        .qb   (qb[h*NBANK+b]),
        .we   (we),
        .wa   ({ctl.y[Y_W-1:BANK_W], ctl.x}),
        .wd   (in_tdata)
      );
    end
  end

  // first stage, lines up with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl;
      s1_v_r   <= in_tdata;
    end
  end

  // bank picks for the neighbour reads
  assign i_c = {~s1_ctl_r.sel, s1_ctl_r.y[BANK_W-1:0]};
  assign i_m = {~s1_ctl_r.sel, s1_ctl_r.y[BANK_W-1:0] - BANK_W'(1)};
  assign i_p = {~s1_ctl_r.sel, s1_ctl_r.y[BANK_W-1:0] + BANK_W'(1)};
  assign i_o = {s1_ctl_r.sel, s1_ctl_r.y[BANK_W-1:0]};

  ste_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .adv     (adv),
    .s1_vld  (s1_vld_r),
    .s1_ctl  (s1_ctl_r),
    .op_xm   (qb[i_c]),
    .op_xp   (qa[i_c]),
    .op_ym   (qa[i_m]),
    .op_yp   (qa[i_p]),
    .op_zm   (qa[i_o]),
    .op_zp   (s1_v_r),
    .out_vld (out_vld),
    .out_val (out_val),
    .out_x   (ox),
    .out_y   (oy),
    .out_z   (oz)
  );

  assign out_tvalid = out_vld;
  assign out_tdata  = {4'b0000, oz, oy, ox, out_val};

endmodule

// ----- sv/ste_checker.sv -----
// ----------------------------------------------------------------------------
// ste_checker
// port-level checks on the stencil, bound to the top level
// ----------------------------------------------------------------------------
module ste_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // a waiting result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // input is held off exactly while a result is blocked
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !(out_tvalid && !out_tready))
    else $error("input ready does not follow output stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result after reset");

  // results are interior points with clean padding
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:32] != 6'd0) && (out_tdata[43:38] != 6'd0) &&
                   (out_tdata[55:52] == 4'd0))
    else $error("result at a halo point");

endmodule

bind stencil_3d_seven_point ste_checker u_ste_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives padded grids through the seven-point stencil and checks every result
// against a behavioural predictor kept in step with each accepted request
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ste_pkg::*;

  typedef struct packed {
    logic        grid_end;
    logic [1:0]  flags;
    logic [31:0] voxel;
  } req_t;

  // laid out as on out_tdata, value in the lowest bits
  typedef struct packed {
    logic [7:0]  z;
    logic [5:0]  y;
    logic [5:0]  x;
    logic [31:0] value;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  stencil_3d_seven_point dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [17:0] weight [7];
  logic signed [31:0] plane_mem [2*64*64];
  logic [5:0] px, py;
  logic [7:0] pz;
  logic [6:0] row_len, plane_rows;
  logic       half;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   quiet_run = 0;      // requests left with no idling
  int   hold_off = 0;       // receiver hold-off cycles left
  int   hold_armed = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic int mem_addr(logic s, logic [5:0] y, logic [5:0] x);
    return (int'(s) * 64 + int'(y)) * 64 + int'(x);
  endfunction

  // advance the stencil predictor by one accepted request
  task automatic predict_stencil(input req_t r);
    logic ge, pe, re;
    logic signed [63:0] acc;
    logic signed [63:0] sh;
    logic signed [31:0] older;
    res_t e;
    ge = r.grid_end;
    pe = ge | r.flags[1];
    re = pe | r.flags[0];
    older = plane_mem[mem_addr(half, py, px)];
    if (pz >= 2 && px >= 1 && py >= 1 && 7'(px) + 7'd2 <= row_len &&
        7'(py) + 7'd2 <= plane_rows) begin
      acc = weight[CFG_CENTER] * plane_mem[mem_addr(~half, py, px)]
          + weight[CFG_X_MINUS] * plane_mem[mem_addr(~half, py, px - 1)]
          + weight[CFG_X_PLUS] * plane_mem[mem_addr(~half, py, px + 1)]
          + weight[CFG_Y_MINUS] * plane_mem[mem_addr(~half, py - 1, px)]
          + weight[CFG_Y_PLUS] * plane_mem[mem_addr(~half, py + 1, px)]
          + weight[CFG_Z_MINUS] * older
          + weight[CFG_Z_PLUS] * $signed(r.voxel);
      sh = acc >>> 16;
      if (sh > 64'sd2147483647) e.value = 32'h7fffffff;
      else if (sh < -64'sd2147483648) e.value = 32'h80000000;
      else e.value = sh[31:0];
      e.x = px;
      e.y = py;
      e.z = pz - 8'd1;
      expected_results.push_back(e);
    end
    plane_mem[mem_addr(half, py, px)] = r.voxel;
    if (re) row_len = 7'(px) + 7'd1;
    if (pe) plane_rows = 7'(py) + 7'd1;
    if (ge) begin
      px = '0; py = '0; pz = '0; half = 1'b0;
    end else if (pe) begin
      px = '0; py = '0;
      if (pz != Z_MAX) pz++;
      half = ~half;
    end else if (re) begin
      px = '0;
      if (py != Y_MAX) py++;
    end else if (px != X_MAX) px++;
  endtask

  // queue one padded grid of w by h by d voxels
  task automatic add_grid(input int w, input int h, input int d, input int mode);
    req_t r;
    for (int z = 0; z < d; z++)
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          case (mode)
            0: r.voxel = $urandom;
            1: r.voxel = 32'h7fffffff;
            2: r.voxel = 32'h80000000;
            default: r.voxel = $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
          endcase
          r.flags[0] = (x == w - 1);
          r.flags[1] = (x == w - 1) && (y == h - 1);
          r.grid_end = (x == w - 1) && (y == h - 1) && (z == d - 1);
          pending_reqs.push_back(r);
        end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [17:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    weight[idx] = val;
  endtask

  task automatic wait_drained;
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_all(input int mode);
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: write_reg(i[IDX_W-1:0], 18'h1ffff);
        1: write_reg(i[IDX_W-1:0], 18'h20000);
        2: write_reg(i[IDX_W-1:0], (i == 0) ? 18'h10000 : 18'h0);
        default: write_reg(i[IDX_W-1:0], 18'($urandom));
      endcase
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) predict_stencil({in_tlast, in_tuser, in_tdata});
        if (pending_reqs.size() != 0 &&
            (quiet_run > 0 || $urandom_range(0, 99) >= 12)) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= r.voxel;
          in_tuser <= r.flags;
          in_tlast <= r.grid_end;
          if (quiet_run > 0) quiet_run <= quiet_run - 1;
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        res_t got;
        got = out_tdata[51:0];
        if (expected_results.size() == 0) report("result with nothing expected");
        else begin
          res_t e;
          e = expected_results.pop_front();
          if (got.value !== e.value)
            report($sformatf("value %h expected %h", got.value, e.value));
          if (got.x !== e.x) report($sformatf("x %0d expected %0d", got.x, e.x));
          if (got.y !== e.y) report($sformatf("y %0d expected %0d", got.y, e.y));
          if (got.z !== e.z) report($sformatf("z %0d expected %0d", got.z, e.z));
        end
      end
      if (hold_armed == 1) begin
        hold_armed <= 2;
        hold_off <= 300;
        out_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else out_tready <= (quiet_run > 0) || ($urandom_range(0, 99) >= 12);
    end
  end

  initial begin
    weight = '{default: '0};
    px = '0; py = '0; pz = '0; row_len = '0; plane_rows = '0; half = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of values and weights, short grid, flag combinations
    set_all(0);
    add_grid(3, 3, 3, 1);
    add_grid(2, 4, 3, 0);
    wait_drained();
    set_all(1);
    add_grid(3, 3, 3, 2);
    add_grid(4, 3, 3, 1);
    wait_drained();
    set_all(2);
    add_grid(4, 4, 3, 3);
    wait_drained();

    // random grids, one long stretch without idling and one long receiver stall
    for (int phase = 0; phase < 4; phase++) begin
      set_all(3);
      if (phase == 1) quiet_run = 200;
      if (phase == 2) hold_armed = 1;
      add_grid($urandom_range(3, 4), $urandom_range(3, 4), 3, $urandom_range(0, 3));
      wait_drained();
    end
    // one grid with overlong rows saturating the column counter
    add_grid(65, 3, 3, 0);
    wait_drained();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
